/* rtl/ktl_pkg.sv */
// Shared types and constants for the keyframe translation interpolator.
// No dependencies.
package ktl_pkg;
  localparam int JOINTS = 16;
  localparam int KEYS = 64;
  localparam int JW = 4;
  localparam int KW = 6;
  localparam int AW = JW + KW;

  localparam logic [2:0] ST_INTERP = 3'd0;
  localparam logic [2:0] ST_SINGLE = 3'd1;
  localparam logic [2:0] ST_EMPTY  = 3'd2;
  localparam logic [2:0] ST_PAST   = 3'd3;
  localparam logic [2:0] ST_ZERO   = 3'd4;

  // Controller to datapath commands
  typedef struct packed {
    logic          capture;   // latch input item
    logic          key_wr;    // write key memories
    logic          rd;        // issue memory read
    logic [KW-1:0] rd_idx;    // key index to read
    logic          ld_t1;     // load probe time (t1) from read data
    logic          ld_a;      // load start key (time+vector)
    logic          ld_b;      // load end key vector
    logic          div_start; // load dividend, clear divider
    logic          div_step;  // one quotient bit
    logic          mul_start; // clear lerp unit
    logic          mul_step;  // one component step
  } ktl_cmd_t;

  typedef struct packed {
    logic        action;
    logic [6:0]  count;
    logic        q_lt_t1;   // query time < key time in read data
    logic        t1_le_t0;  // t1 <= t0
  } ktl_stat_t;
endpackage

/* rtl/ktl_datapath.sv */
// Datapath: key memories, track counts, serial divider and lerp unit.
// Depends on ktl_pkg.
module ktl_datapath import ktl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  ktl_cmd_t           cmd,
  output ktl_stat_t          stat,
  input  logic               in_action,
  input  logic [3:0]         in_joint,
  input  logic [5:0]         in_key_index,
  input  logic [31:0]        in_key_time,
  input  logic signed [31:0] in_key_x,
  input  logic signed [31:0] in_key_y,
  input  logic signed [31:0] in_key_z,
  input  logic               in_last_key,
  input  logic [31:0]        in_query_time,
  output logic signed [31:0] res_x,
  output logic signed [31:0] res_y,
  output logic signed [31:0] res_z
);
  logic [31:0] mem_t [JOINTS*KEYS];
  logic [31:0] mem_x [JOINTS*KEYS];
  logic [31:0] mem_y [JOINTS*KEYS];
  logic [31:0] mem_z [JOINTS*KEYS];
  logic [6:0]  cnt_r [JOINTS];

  logic        act_r, last_r;
  logic [3:0]  joint_r;
  logic [5:0]  kidx_r;
  logic [31:0] ktime_r, kx_r, ky_r, kz_r, qtime_r;
  logic [31:0] rt_r, rx_r, ry_r, rz_r;
  logic [31:0] t0_r, t1_r;
  logic [31:0] ax_r, ay_r, az_r, bx_r, by_r, bz_r;

  // divider
  logic [47:0] num_r;
  logic [32:0] rem_r;
  logic [16:0] quo_r;
  logic [32:0] rem_sh;
  logic [31:0] span;
  // lerp
  logic [1:0]  comp_r;
  logic signed [31:0] ox_r, oy_r, oz_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= in_action; joint_r <= in_joint; kidx_r <= in_key_index;
      ktime_r <= in_key_time; kx_r <= in_key_x; ky_r <= in_key_y;
      kz_r <= in_key_z; last_r <= in_last_key; qtime_r <= in_query_time;
    end
    if (cmd.key_wr) begin
      mem_t[{joint_r, kidx_r}] <= ktime_r;
      mem_x[{joint_r, kidx_r}] <= kx_r;
      mem_y[{joint_r, kidx_r}] <= ky_r;
      mem_z[{joint_r, kidx_r}] <= kz_r;
    end
    if (cmd.rd) begin
      rt_r <= mem_t[{joint_r, cmd.rd_idx}];
      rx_r <= mem_x[{joint_r, cmd.rd_idx}];
      ry_r <= mem_y[{joint_r, cmd.rd_idx}];
      rz_r <= mem_z[{joint_r, cmd.rd_idx}];
    end
    if (cmd.ld_t1) t1_r <= rt_r;
    if (cmd.ld_a) begin
      t0_r <= rt_r; ax_r <= rx_r; ay_r <= ry_r; az_r <= rz_r;
    end
    if (cmd.ld_b) begin
      bx_r <= rx_r; by_r <= ry_r; bz_r <= rz_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < JOINTS; j++) cnt_r[j] <= '0;
    end else if (cmd.key_wr && last_r) begin
      cnt_r[joint_r] <= {1'b0, kidx_r} + 7'd1;
    end
  end

  assign span = t1_r - t0_r;
  assign rem_sh = {rem_r[31:0], num_r[47]};

  // restoring divider, one quotient bit per step; fraction saturates at 16 bits
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      num_r <= (qtime_r > t0_r) ? {qtime_r - t0_r, 16'd0} : 48'd0;
      rem_r <= '0;
      quo_r <= '0;
    end else if (cmd.div_step) begin
      num_r <= {num_r[46:0], 1'b0};
      if (rem_sh >= {1'b0, span}) begin
        rem_r <= rem_sh - {1'b0, span};
        quo_r <= {quo_r[15:0], 1'b1};
      end else begin
        rem_r <= rem_sh;
        quo_r <= {quo_r[15:0], 1'b0};
      end
    end
  end

  // lerp: one component per step, shared multiplier
  logic [15:0] frac;
  logic signed [32:0] d;
  logic signed [49:0] p;
  logic signed [33:0] q;
  logic signed [34:0] s;
  logic signed [31:0] v0, v1, sat;
  assign frac = (quo_r > 17'd65535) ? 16'hFFFF : quo_r[15:0];
  always_comb begin
    case (comp_r)
      2'd0: begin v0 = ax_r; v1 = bx_r; end
      2'd1: begin v0 = ay_r; v1 = by_r; end
      default: begin v0 = az_r; v1 = bz_r; end
    endcase
    d = 33'(v1) - 33'(v0);
    p = 50'(d) * $signed({34'd0, frac});
    q = 34'(p >>> 16);
    s = 35'(v0) + 35'(q);
    if (s > 35'sd2147483647) sat = 32'sh7FFFFFFF;
    else if (s < -35'sd2147483648) sat = 32'sh80000000;
    else sat = s[31:0];
  end

  // result vector: start key on ld_a, lerp output per step
  always_ff @(posedge clk) begin
    if (cmd.mul_start) comp_r <= '0;
    else if (cmd.mul_step) comp_r <= comp_r + 2'd1;
    if (cmd.ld_a) begin
      ox_r <= rx_r; oy_r <= ry_r; oz_r <= rz_r;
    end else if (cmd.mul_step) begin
      case (comp_r)
        2'd0: ox_r <= sat;
        2'd1: oy_r <= sat;
        default: oz_r <= sat;
      endcase
    end
  end

  assign stat.action   = act_r;
  assign stat.count    = (cnt_r[joint_r] > 7'(KEYS)) ? 7'(KEYS) : cnt_r[joint_r];
  assign stat.q_lt_t1  = qtime_r < rt_r;
  assign stat.t1_le_t0 = rt_r <= t0_r;
  assign res_x = ox_r;
  assign res_y = oy_r;
  assign res_z = oz_r;
endmodule

/* rtl/ktl_ctrl.sv */
// Controller state machine sequencing search, divide and lerp.
// Depends on ktl_pkg.
module ktl_ctrl import ktl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  output ktl_cmd_t  cmd,
  input  ktl_stat_t stat,
  output logic      out_valid,
  output logic [5:0] seg_out,
  output logic [2:0] status_out,
  output logic      zero_vec
);
  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_SRD, S_SCMP, S_ARD, S_AWT, S_ALD, S_BLD, S_DIV, S_MUL, S_DONE
  } state_t;

  state_t     st_r, st_nxt;
  logic [5:0] i_r, i_nxt;
  logic [5:0] cnt6;
  logic [5:0] n_r, n_nxt;
  logic [2:0] status_r, status_nxt;
  logic       ov_r, ov_nxt, zv_r, zv_nxt;

  assign cnt6 = stat.count[5:0] - 6'd1;

  always_comb begin
    st_nxt = st_r; i_nxt = i_r; n_nxt = n_r; status_nxt = status_r;
    ov_nxt = 1'b0; zv_nxt = zv_r;
    cmd = '0;
    cmd.rd_idx = i_r;
    case (st_r)
      S_IDLE: if (start) begin cmd.capture = 1'b1; st_nxt = S_DEC; end
      S_DEC: begin
        if (!stat.action) begin
          cmd.key_wr = 1'b1; st_nxt = S_IDLE;
        end else if (stat.count == 7'd0) begin
          status_nxt = ST_EMPTY; zv_nxt = 1'b1; i_nxt = '0; ov_nxt = 1'b1; st_nxt = S_IDLE;
        end else if (stat.count == 7'd1) begin
          status_nxt = ST_SINGLE; zv_nxt = 1'b0; i_nxt = '0; st_nxt = S_ARD;
        end else begin
          i_nxt = 6'd1; zv_nxt = 1'b0; st_nxt = S_SRD;
        end
      end
      S_SRD: begin cmd.rd = 1'b1; st_nxt = S_SCMP; end
      S_SCMP: begin
        if (stat.q_lt_t1) begin
          cmd.ld_t1 = 1'b1; i_nxt = i_r - 6'd1; status_nxt = ST_INTERP; st_nxt = S_ARD;
        end else if (i_r == cnt6) begin
          status_nxt = ST_PAST; st_nxt = S_ARD;
        end else begin
          i_nxt = i_r + 6'd1; st_nxt = S_SRD;
        end
      end
      S_ARD: begin cmd.rd = 1'b1; st_nxt = S_ALD; end
      S_ALD: begin
        cmd.ld_a = 1'b1;
        if (status_r != ST_INTERP) begin
          ov_nxt = 1'b1; st_nxt = S_IDLE;
        end else begin
          cmd.rd_idx = i_r + 6'd1; cmd.rd = 1'b1; st_nxt = S_AWT;
        end
      end
      S_AWT: begin
        cmd.ld_b = 1'b1;
        if (stat.t1_le_t0) begin
          status_nxt = ST_ZERO; ov_nxt = 1'b1; st_nxt = S_IDLE;
        end else begin
          cmd.div_start = 1'b1; n_nxt = 6'd0; st_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1; n_nxt = n_r + 6'd1;
        if (n_r == 6'd47) st_nxt = S_BLD;
      end
      S_BLD: begin cmd.mul_start = 1'b1; n_nxt = '0; st_nxt = S_MUL; end
      S_MUL: begin
        cmd.mul_step = 1'b1; n_nxt = n_r + 6'd1;
        if (n_r == 6'd2) st_nxt = S_DONE;
      end
      S_DONE: begin ov_nxt = 1'b1; st_nxt = S_IDLE; end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; i_r <= '0; n_r <= '0; status_r <= '0; ov_r <= 1'b0; zv_r <= 1'b0;
    end else begin
      st_r <= st_nxt; i_r <= i_nxt; n_r <= n_nxt; status_r <= status_nxt;
      ov_r <= ov_nxt; zv_r <= zv_nxt;
    end
  end

  assign busy = (st_r != S_IDLE);
  assign out_valid = ov_r;
  assign seg_out = i_r;
  assign status_out = status_r;
  assign zero_vec = zv_r;

  a_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("start not taken");
  a_strobe_1: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("strobe longer than one cycle");
  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
endmodule

/* rtl/keyframe_translation_lerp.sv */
// Top level of the keyframe translation interpolator.
// Depends on ktl_pkg, ktl_ctrl and ktl_datapath.
//
// Pulse start while busy is low to hand in one transaction. action 0 writes
// a key (no result); action 1 queries a joint at query_time and
// gives one result with out_valid high for exactly one cycle; the receiver
// cannot stall, so capture it then. A query scans the keys by linear search,
// reading and comparing one key at a time, then for an interpolated answer
// runs the bit-serial divider (1 bit/cycle) and a lerp of the three
// components through one shared multiplier before the strobe.
// Key memories are not cleared: only keys that were written may be queried.
module keyframe_translation_lerp import ktl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_action,
  input  logic [3:0]         in_joint,
  input  logic [5:0]         in_key_index,
  input  logic [31:0]        in_key_time,
  input  logic signed [31:0] in_key_x,
  input  logic signed [31:0] in_key_y,
  input  logic signed [31:0] in_key_z,
  input  logic               in_last_key,
  input  logic [31:0]        in_query_time,
  output logic               out_valid,
  output logic signed [31:0] out_x,
  output logic signed [31:0] out_y,
  output logic signed [31:0] out_z,
  output logic [5:0]         out_segment,
  output logic [2:0]         out_status
);
  ktl_cmd_t  cmd;
  ktl_stat_t stat;
  logic signed [31:0] rx, ry, rz;
  logic zero_vec;

  ktl_ctrl u_ctrl (
    .clk, .rst_n, .start, .busy, .cmd, .stat, .out_valid,
    .seg_out(out_segment), .status_out(out_status), .zero_vec
  );

  ktl_datapath u_dp (
    .clk, .rst_n, .cmd, .stat,
    .in_action, .in_joint, .in_key_index, .in_key_time,
    .in_key_x, .in_key_y, .in_key_z, .in_last_key, .in_query_time,
    .res_x(rx), .res_y(ry), .res_z(rz)
  );

  // empty track answers a zero vector
  assign out_x = zero_vec ? '0 : rx;
  assign out_y = zero_vec ? '0 : ry;
  assign out_z = zero_vec ? '0 : rz;
endmodule

/* tb/testbench.sv */
// Self-checking testbench for keyframe_translation_lerp: key writes and joint queries.
// Depends on ktl_pkg and the keyframe_translation_lerp RTL.
// Predicts every query result and compares each one against the out_* strobe.
module testbench import ktl_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT = 2000000;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic [5:0]  seg;
    logic [2:0]  st;
  } pose_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_action = 1'b0;
  logic [3:0] in_joint = '0;
  logic [5:0] in_key_index = '0;
  logic [31:0] in_key_time = '0;
  logic signed [31:0] in_key_x = '0, in_key_y = '0, in_key_z = '0;
  logic in_last_key = 1'b0;
  logic [31:0] in_query_time = '0;
  logic out_valid;
  logic signed [31:0] out_x, out_y, out_z;
  logic [5:0] out_segment;
  logic [2:0] out_status;

  // predictor state
  logic [31:0] pt [JOINTS][KEYS];
  logic [31:0] px [JOINTS][KEYS];
  logic [31:0] py [JOINTS][KEYS];
  logic [31:0] pz [JOINTS][KEYS];
  logic [6:0]  pcount [JOINTS];

  pose_t pending_poses[$];
  int errors = 0;
  int cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  keyframe_translation_lerp dut (.*);

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic signed [31:0] lerp_axis(logic [31:0] a, logic [31:0] b,
                                                     logic [31:0] frac);
    longint v0, v1, p, q, r;
    v0 = longint'($signed(a));
    v1 = longint'($signed(b));
    p = (v1 - v0) * longint'(frac);
    if (p >= 0) q = p >>> 16;
    else q = -((-p + 65535) >>> 16);
    r = v0 + q;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  function automatic pose_t predict_pose(logic [3:0] j, logic [31:0] qt);
    pose_t r;
    int n, s;
    bit found;
    logic [31:0] t0, t1, frac;
    logic [63:0] diff, span;
    n = pcount[j];
    r.seg = '0;
    if (n == 0) begin
      r.x = 0; r.y = 0; r.z = 0; r.st = ST_EMPTY;
      return r;
    end
    if (n == 1) begin
      r.x = px[j][0]; r.y = py[j][0]; r.z = pz[j][0]; r.st = ST_SINGLE;
      return r;
    end
    s = n - 1;
    found = 0;
    for (int i = 0; i + 1 < n; i++) begin
      if (!found && qt < pt[j][i+1]) begin
        s = i; found = 1;
      end
    end
    r.seg = s[5:0];
    r.x = px[j][s]; r.y = py[j][s]; r.z = pz[j][s];
    if (!found) begin
      r.st = ST_PAST;
      return r;
    end
    t0 = pt[j][s];
    t1 = pt[j][s+1];
    if (t1 <= t0) begin
      r.st = ST_ZERO;
      return r;
    end
    frac = 0;
    if (qt > t0) begin
      diff = {32'd0, qt - t0};
      span = {32'd0, t1 - t0};
      diff = (diff << 16) / span;
      frac = (diff > 65535) ? 32'd65535 : diff[31:0];
    end
    r.x = lerp_axis(px[j][s], px[j][s+1], frac);
    r.y = lerp_axis(py[j][s], py[j][s+1], frac);
    r.z = lerp_axis(pz[j][s], pz[j][s+1], frac);
    r.st = ST_INTERP;
    return r;
  endfunction

  // sender gap state: bursts with random gaps
  int burst_left = 0;

  // start stays high across back-to-back items; it drops only for a gap
  task automatic send_item(input logic act, input logic [3:0] j, input logic [5:0] k,
                           input logic [31:0] kt, input logic [31:0] kx,
                           input logic [31:0] ky, input logic [31:0] kz,
                           input logic lk, input logic [31:0] qt);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    in_action <= act; in_joint <= j; in_key_index <= k; in_key_time <= kt;
    in_key_x <= kx; in_key_y <= ky; in_key_z <= kz; in_last_key <= lk;
    in_query_time <= qt;
    @(posedge clk);
    while (busy) @(posedge clk);
    // transaction accepted at this edge
    if (act == 1'b0) begin
      pt[j][k] = kt; px[j][k] = kx; py[j][k] = ky; pz[j][k] = kz;
      if (lk) pcount[j] = {1'b0, k} + 7'd1;
    end else begin
      pending_poses.insert(pending_poses.size(), predict_pose(j, qt));
    end
  endtask

  task automatic write_key(input int j, input int k, input logic [31:0] kt, input bit lk);
    send_item(1'b0, 4'(j), 6'(k), kt, $urandom, $urandom, $urandom, lk, $urandom);
  endtask

  task automatic query(input int j, input logic [31:0] qt);
    send_item(1'b1, 4'(j), 6'($urandom), $urandom, $urandom, $urandom, $urandom,
              1'($urandom), qt);
  endtask

  // checker of each result strobe
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      pose_t e;
      if (pending_poses.size() == 0) begin
        report("unexpected result", out_status, 0);
      end else begin
        e = pending_poses.pop_front();
        if (out_x !== e.x) report("x", out_x, e.x);
        if (out_y !== e.y) report("y", out_y, e.y);
        if (out_z !== e.z) report("z", out_z, e.z);
        if (out_segment !== e.seg) report("segment", out_segment, e.seg);
        if (out_status !== e.st) report("status", out_status, e.st);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // Build a track of n keys with ascending (optionally repeated) times.
  task automatic build_track(input int j, input int n, input bit dups);
    logic [31:0] t;
    t = $urandom_range(0, 1000);
    for (int k = 0; k < n; k++) begin
      write_key(j, k, t, k == n - 1);
      if (!(dups && $urandom_range(0, 3) == 0))
        t = t + $urandom_range(1, 1 << $urandom_range(1, 20));
    end
  endtask

  function automatic logic [31:0] pick_time(int j);
    int n, k;
    n = pcount[j];
    k = $urandom_range(0, n - 1);
    case ($urandom_range(0, 4))
      0: return pt[j][k];
      1: return pt[j][k] + $urandom_range(0, 4096);
      2: return pt[j][k] - 1;
      3: return $urandom;
      default: return pt[j][n-1] + $urandom_range(0, 100);
    endcase
  endfunction

  task automatic test_directed();
    query(0, 32'd0);                     // empty track
    write_key(1, 0, 32'h100, 1'b1);      // single key
    query(1, 32'h0);
    query(1, 32'hFFFF_FFFF);
    send_item(1'b0, 4'd2, 6'd0, 32'h10, 32'h7FFF_FFFF, 32'h8000_0000, 32'd0, 1'b0, 32'd0);
    send_item(1'b0, 4'd2, 6'd1, 32'h20, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
              1'b0, 32'd0);
    send_item(1'b0, 4'd2, 6'd2, 32'h20, 32'd1, 32'd2, 32'd3, 1'b0, 32'd0);  // zero-length
    send_item(1'b0, 4'd2, 6'd3, 32'hFFFF_FFFF, 32'd5, 32'd6, 32'd7, 1'b1, 32'd0);
    query(2, 32'h0);                     // before first key
    query(2, 32'h18);
    query(2, 32'h1F);
    query(2, 32'h20);                    // lands on the key after the zero-length segment
    query(2, 32'hFFFF_FFFE);
    query(2, 32'hFFFF_FFFF);             // past end
    build_track(3, 64, 1'b0);            // full track, key index 63
    query(3, 32'hFFFF_FFFF);
    query(3, pt[3][62] + 1);
    write_key(15, 0, 32'd0, 1'b0);
    write_key(15, 1, 32'hFFFF_FFFF, 1'b1);
    query(15, 32'h8000_0000);
  endtask

  task automatic test_random();
    int j;
    for (int it = 0; it < 1950; ) begin
      j = $urandom_range(0, 15);
      if ($urandom_range(0, 9) == 0 || pcount[j] == 0) begin
        int n;
        n = ($urandom_range(0, 15) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 8);
        build_track(j, n, 1'($urandom_range(0, 1)));
        it += n;
      end else if ($urandom_range(0, 7) == 0) begin
        // rewrite an in-range key, keeping the count
        int k;
        k = $urandom_range(0, pcount[j] - 1);
        send_item(1'b0, 4'(j), 6'(k), $urandom, $urandom, $urandom, $urandom, 1'b0, 32'd0);
        it++;
      end else begin
        query(j, pick_time(j));
        it++;
      end
    end
  endtask

  initial begin
    for (int j = 0; j < JOINTS; j++) pcount[j] = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random();
    start <= 1'b0;
    while (pending_poses.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end
endmodule
